>>> sv/largest_empty_square_stream_defines.svh
// Assertion macros used by the checker of the block.
`ifndef LARGEST_EMPTY_SQUARE_STREAM_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_STREAM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LES_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LES_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/les_pkg.sv
package les_pkg;

  // Field widths of the channels and the configuration register.
  localparam int IMAGE_SIDE_W = 11;
  localparam int PIXEL_W = 1;
  localparam int LARGEST_SIDE_W = 11;

  // Default capacity of the line buffer and the side after reset.
  localparam int MAX_SIDE_DEFAULT = 1024;
  localparam int IMAGE_SIDE_RESET = 1024;

  // Largest value the result field can carry.
  localparam int OUT_LIMIT = 2047;

endpackage

>>> sv/les_if.sv
interface les_pixel_if;
  import les_pkg::*;

  logic valid;
  logic ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface les_result_if;
  import les_pkg::*;

  logic valid;
  logic ready;
  logic [LARGEST_SIDE_W-1:0] largest_side;

  modport source (output valid, output largest_side, input ready);
  modport sink (input valid, input largest_side, output ready);
endinterface

>>> sv/les_cell.sv
module les_cell #(
  parameter int VAL_W = 11,
  parameter int IDX_W = 10,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] entry,
  input  logic [VAL_W-1:0] here,
  input  logic [VAL_W-1:0] prev,
  output logic [VAL_W-1:0] value
);

  // The cell at the entry point loads the new value; every other cell takes
  // the value of its left neighbor, so a value reaches the end of the line
  // exactly one image row after it was written.
  always_ff @(posedge clk) begin
    if (en) begin
      value <= (entry == IDX_W'(INDEX)) ? here : prev;
    end
  end

endmodule

>>> sv/les_row_line.sv
module les_row_line #(
  parameter int MAX_SIDE = 1024,
  parameter int VAL_W = 11,
  parameter int IDX_W = 10
) (
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] entry,
  input  logic [VAL_W-1:0] here,
  output logic [VAL_W-1:0] up
);

  logic [VAL_W-1:0] taps [MAX_SIDE];

  // A chain of cells that delays each side value by one image row.
  for (genvar i = 0; i < MAX_SIDE; i++) begin : g_cell
    if (i == 0) begin : g_first
      les_cell #(.VAL_W(VAL_W), .IDX_W(IDX_W), .INDEX(i)) u_cell (
        .clk   (clk),
        .en    (en),
        .entry (entry),
        .here  (here),
        .prev  (here),
        .value (taps[i])
      );
    end else begin : g_rest
      les_cell #(.VAL_W(VAL_W), .IDX_W(IDX_W), .INDEX(i)) u_cell (
        .clk   (clk),
        .en    (en),
        .entry (entry),
        .here  (here),
        .prev  (taps[i-1]),
        .value (taps[i])
      );
    end
  end

  // The last cell holds the value of the pixel one row above.
  assign up = taps[MAX_SIDE-1];

endmodule

>>> sv/largest_empty_square_stream.sv
// Largest all-white square over a streamed square binary image.
// Pixels arrive on the pixels channel (valid/ready), one request per pixel,
// in raster order; 0 is white and 1 is black. The user must write the image
// side through cfg_we/cfg_wdata only while the block is idle; the block does
// not enforce this. 0 acts as 1 and values above MAX_SIDE act as MAX_SIDE. A
// write abandons any image in progress. After the last pixel of each image
// one request on the squares channel carries the side of the largest all-white
// square of that image. Throughput is one pixel per clock unless a pending
// result holds back the last pixel. The result is registered when the last
// pixel is accepted. Each pixel's side is a three-way minimum and an increment
// against a chain of MAX_SIDE cells that delays every value by exactly one
// image row. While a result waits, pixels are still accepted; only the last
// pixel of the next image waits until the pending result is taken. Reset sets
// the side to 1024 (limited to MAX_SIDE), the position to the first pixel and
// the running maximum to zero. The line cells are not cleared; the first row
// of every image overwrites them before any read.
module largest_empty_square_stream #(
  parameter int MAX_SIDE = les_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  les_pixel_if.sink                         pixels,
  les_result_if.source                      squares,
  input  logic                              cfg_we,
  input  logic [les_pkg::IMAGE_SIDE_W-1:0]  cfg_wdata
);
  import les_pkg::*;

  localparam int VAL_W = $clog2(MAX_SIDE + 1);
  localparam int IDX_W = $clog2(MAX_SIDE);
  localparam int CW = (IMAGE_SIDE_W > VAL_W) ? IMAGE_SIDE_W : VAL_W;
  localparam int RESET_SIDE = (IMAGE_SIDE_RESET > MAX_SIDE) ? MAX_SIDE : IMAGE_SIDE_RESET;

  logic [IDX_W-1:0] side_m1;
  logic [IDX_W-1:0] entry;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic [VAL_W-1:0] left_side;
  logic [VAL_W-1:0] diagonal_side;
  logic [VAL_W-1:0] best_side;
  logic [VAL_W-1:0] up;
  logic [VAL_W-1:0] here;
  logic [VAL_W-1:0] min_side;
  logic [VAL_W-1:0] best_next;
  logic [CW-1:0] cfg_wide;
  logic [IDX_W-1:0] side_m1_next;
  logic [LARGEST_SIDE_W-1:0] result_next;
  logic last_col;
  logic last_pixel;
  logic accept;
  logic out_valid;
  logic [LARGEST_SIDE_W-1:0] out_data;

  // Position flags and the input handshake.
  assign last_col = (col == side_m1);
  assign last_pixel = last_col && (row == side_m1);
  assign pixels.ready = !(last_pixel && out_valid && !squares.ready);
  assign accept = pixels.valid && pixels.ready;

  // Side of the largest white square ending at this pixel.
  always_comb begin
    min_side = up;
    if (left_side < min_side) begin
      min_side = left_side;
    end
    if (diagonal_side < min_side) begin
      min_side = diagonal_side;
    end
    if (pixels.pixel[0]) begin
      here = '0;
    end else if (row == '0 || col == '0) begin
      here = VAL_W'(1);
    end else begin
      here = min_side + VAL_W'(1);
    end
    best_next = (here > best_side) ? here : best_side;
    if (CW'(best_next) > CW'(OUT_LIMIT)) begin
      result_next = LARGEST_SIDE_W'(OUT_LIMIT);
    end else begin
      result_next = LARGEST_SIDE_W'(best_next);
    end
  end

  // Limit a written side to the range the line buffer supports.
  always_comb begin
    cfg_wide = CW'(cfg_wdata);
    if (cfg_wide == '0) begin
      side_m1_next = '0;
    end else if (cfg_wide > CW'(MAX_SIDE)) begin
      side_m1_next = IDX_W'(MAX_SIDE - 1);
    end else begin
      side_m1_next = IDX_W'(cfg_wide - CW'(1));
    end
  end

  // Row delay line.
  les_row_line #(.MAX_SIDE(MAX_SIDE), .VAL_W(VAL_W), .IDX_W(IDX_W)) u_row_line (
    .clk   (clk),
    .en    (accept),
    .entry (entry),
    .here  (here),
    .up    (up)
  );

  // Side register, position, neighbors and running maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_m1 <= IDX_W'(RESET_SIDE - 1);
      entry <= IDX_W'(MAX_SIDE - RESET_SIDE);
      row <= '0;
      col <= '0;
      left_side <= '0;
      diagonal_side <= '0;
      best_side <= '0;
    end else if (cfg_we) begin
      side_m1 <= side_m1_next;
      entry <= IDX_W'(MAX_SIDE - 1) - side_m1_next;
      row <= '0;
      col <= '0;
      left_side <= '0;
      diagonal_side <= '0;
      best_side <= '0;
    end else if (accept) begin
      if (last_pixel) begin
        row <= '0;
        col <= '0;
        left_side <= '0;
        diagonal_side <= '0;
        best_side <= '0;
      end else begin
        if (last_col) begin
          col <= '0;
          row <= row + IDX_W'(1);
        end else begin
          col <= col + IDX_W'(1);
        end
        left_side <= here;
        diagonal_side <= up;
        best_side <= best_next;
      end
    end
  end

  // Output register holding the finished result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_pixel) begin
      out_valid <= 1'b1;
    end else if (squares.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_pixel) begin
      out_data <= result_next;
    end
  end

  assign squares.valid = out_valid;
  assign squares.largest_side = out_data;

endmodule

>>> sv/les_checker.sv
`include "largest_empty_square_stream_defines.svh"

module les_checker #(
  parameter int MAX_SIDE = 1024
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              pix_ready,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic [les_pkg::LARGEST_SIDE_W-1:0] res_side
);

  // A stalled result holds its value.
  `LES_ASSERT_NEXT(a_result_holds, clk, rst, res_valid && !res_ready, res_valid && $stable(res_side))

  // No square can be larger than the supported image side.
  `LES_ASSERT_NOW(a_result_bounded, clk, rst, res_valid, int'(res_side) <= MAX_SIDE)

  // Reset leaves no result pending.
  `LES_ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, !res_valid)

  // Pixels are only held back by a pending result.
  `LES_ASSERT_NOW(a_ready_when_free, clk, rst, !res_valid, pix_ready)

endmodule

bind largest_empty_square_stream les_checker #(.MAX_SIDE(MAX_SIDE)) u_les_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pixels.ready),
  .res_valid (squares.valid),
  .res_ready (squares.ready),
  .res_side  (squares.largest_side)
);
